// ===== hdl/hex_record_deframer_core_macros.svh =====
// Assertion macros for the hex record deframer checker.
`ifndef HEX_RECORD_DEFRAMER_CORE_MACROS_SVH
`define HEX_RECORD_DEFRAMER_CORE_MACROS_SVH

// Property checked only outside reset.
`define HRD_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("hrd assertion failed");

// Property checked at every edge, reset included.
`define HRD_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("hrd assertion failed");

`endif

// ===== hdl/hrd_pkg.sv =====
// Types and constants shared by the hex record deframer modules.
`default_nettype none

package hrd_pkg;

  localparam logic [7:0] TYPE_DATA = 8'd0;
  localparam logic [7:0] TYPE_END  = 8'd1;
  localparam logic [7:0] TYPE_BASE = 8'd4;

  localparam logic [7:0] SEG_BOOT = 8'd1;
  localparam logic [7:0] SEG_FIRM = 8'd3;

  localparam logic [2:0] KIND_DATA        = 3'd0;
  localparam logic [2:0] KIND_BOOT_WRITE  = 3'd1;
  localparam logic [2:0] KIND_FIRM_WRITE  = 3'd2;
  localparam logic [2:0] KIND_APPLY       = 3'd3;
  localparam logic [2:0] KIND_APPLY_FINAL = 3'd4;
  localparam logic [2:0] KIND_BASE_SET    = 3'd5;
  localparam logic [2:0] KIND_IGNORED     = 3'd6;

  typedef enum logic [6:0] {
    PH_LEN    = 7'b0000001,
    PH_OFF_HI = 7'b0000010,
    PH_OFF_LO = 7'b0000100,
    PH_TYPE   = 7'b0001000,
    PH_DATA   = 7'b0010000,
    PH_CHECK  = 7'b0100000,
    PH_SEG    = 7'b1000000
  } phase_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data_value;
    logic [7:0]  byte_index;
    logic [31:0] target_address;
    logic [7:0]  record_length;
    logic [7:0]  record_type;
    logic [7:0]  check_value;
    logic [7:0]  segment_tag;
    logic        last_of_record;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/hrd_parser.sv =====
// Record parser: field capture state and per-byte result generation.
`default_nettype none

module hrd_parser (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            go_i,
  input  wire logic [7:0]      byte_i,
  output logic                 res_valid_o,
  output hrd_pkg::result_t     res_o
);

  hrd_pkg::phase_e phase_q, phase_d;
  logic [7:0]  byte_count_q, byte_count_d;
  logic [7:0]  rec_len_q, rec_len_d;
  logic [15:0] rec_offset_q, rec_offset_d;
  logic [7:0]  rec_kind_q, rec_kind_d;
  logic [7:0]  rec_check_q, rec_check_d;
  logic [15:0] first_payload_q, first_payload_d;
  logic [15:0] base_upper_q, base_upper_d;
  logic        finished_q, finished_d;
  logic        has_res;
  logic [7:0]  count_inc;

  assign count_inc = byte_count_q + 8'd1;

  always_comb begin
    phase_d         = phase_q;
    byte_count_d    = byte_count_q;
    rec_len_d       = rec_len_q;
    rec_offset_d    = rec_offset_q;
    rec_kind_d      = rec_kind_q;
    rec_check_d     = rec_check_q;
    first_payload_d = first_payload_q;
    base_upper_d    = base_upper_q;
    finished_d      = finished_q;
    has_res         = 1'b0;
    res_o           = '0;
    if (!finished_q) begin
      case (phase_q)
        hrd_pkg::PH_OFF_HI: begin
          rec_offset_d = {byte_i, 8'h00};
          phase_d      = hrd_pkg::PH_OFF_LO;
        end
        hrd_pkg::PH_OFF_LO: begin
          rec_offset_d = {rec_offset_q[15:8], byte_i};
          phase_d      = hrd_pkg::PH_TYPE;
        end
        hrd_pkg::PH_TYPE: begin
          rec_kind_d      = byte_i;
          first_payload_d = '0;
          byte_count_d    = '0;
          phase_d         = (rec_len_q == 8'd0) ? hrd_pkg::PH_CHECK : hrd_pkg::PH_DATA;
        end
        hrd_pkg::PH_DATA: begin
          has_res          = 1'b1;
          res_o.kind       = hrd_pkg::KIND_DATA;
          res_o.data_value = byte_i;
          res_o.byte_index = byte_count_q;
          if (byte_count_q == 8'd0) begin
            first_payload_d = {byte_i, 8'h00};
          end else if (byte_count_q == 8'd1) begin
            first_payload_d = {first_payload_q[15:8], byte_i};
          end
          byte_count_d = count_inc;
          if (count_inc == rec_len_q) begin
            phase_d = hrd_pkg::PH_CHECK;
          end
        end
        hrd_pkg::PH_CHECK: begin
          rec_check_d = byte_i;
          phase_d     = hrd_pkg::PH_SEG;
        end
        hrd_pkg::PH_SEG: begin
          has_res              = 1'b1;
          phase_d              = hrd_pkg::PH_LEN;
          res_o.record_length  = rec_len_q;
          res_o.record_type    = rec_kind_q;
          res_o.check_value    = rec_check_q;
          res_o.segment_tag    = byte_i;
          res_o.last_of_record = 1'b1;
          if (rec_kind_q == hrd_pkg::TYPE_DATA) begin
            if (byte_i == hrd_pkg::SEG_BOOT) begin
              res_o.kind = hrd_pkg::KIND_BOOT_WRITE;
            end else begin
              res_o.kind           = hrd_pkg::KIND_FIRM_WRITE;
              res_o.target_address = {base_upper_q, rec_offset_q};
            end
          end else if (rec_kind_q == hrd_pkg::TYPE_END) begin
            if (byte_i == hrd_pkg::SEG_FIRM) begin
              res_o.kind = hrd_pkg::KIND_APPLY_FINAL;
              finished_d = 1'b1;
            end else begin
              res_o.kind = hrd_pkg::KIND_APPLY;
            end
          end else if (rec_kind_q == hrd_pkg::TYPE_BASE) begin
            base_upper_d = first_payload_q;
            res_o.kind   = hrd_pkg::KIND_BASE_SET;
          end else begin
            res_o.kind = hrd_pkg::KIND_IGNORED;
          end
        end
        default: begin
          rec_len_d = byte_i;
          phase_d   = hrd_pkg::PH_OFF_HI;
        end
      endcase
    end
  end

  assign res_valid_o = go_i & has_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= hrd_pkg::PH_LEN;
      byte_count_q    <= '0;
      rec_len_q       <= '0;
      rec_offset_q    <= '0;
      rec_kind_q      <= '0;
      rec_check_q     <= '0;
      first_payload_q <= '0;
      base_upper_q    <= '0;
      finished_q      <= 1'b0;
    end else if (go_i) begin
      phase_q         <= phase_d;
      byte_count_q    <= byte_count_d;
      rec_len_q       <= rec_len_d;
      rec_offset_q    <= rec_offset_d;
      rec_kind_q      <= rec_kind_d;
      rec_check_q     <= rec_check_d;
      first_payload_q <= first_payload_d;
      base_upper_q    <= base_upper_d;
      finished_q      <= finished_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/hrd_out_reg.sv =====
// Result register with valid/ready hand-off to the output channel.
`default_nettype none

module hrd_out_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire hrd_pkg::result_t res_i,
  input  wire logic             out_ready_i,
  output logic                  out_valid_o,
  output hrd_pkg::result_t      res_o
);

  logic             valid_q, valid_d;
  hrd_pkg::result_t res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== hdl/hex_record_deframer_core.sv =====
// Top level of the hex record deframer: input register, parser, result register.
// Accepts one received byte per cycle and parses binary hex-style records
// (length, 16-bit offset, type, payload, check, segment). Each payload byte
// gives a data item; the segment byte gives one command item. A byte is
// registered in the input register on acceptance and parsed into the result
// register once that register is empty or being drained, and the sustained
// rate is one byte per cycle as long as results are taken. The input accepts
// whenever the input register is empty or drains into the result register,
// which drains when out_ready_i is high. After an apply final command all
// further bytes are accepted and dropped until reset.
`default_nettype none

module hex_record_deframer_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       kind_o,
  output logic [7:0]       data_value_o,
  output logic [7:0]       byte_index_o,
  output logic [31:0]      target_address_o,
  output logic [7:0]       record_length_o,
  output logic [7:0]       record_type_o,
  output logic [7:0]       check_value_o,
  output logic [7:0]       segment_tag_o,
  output logic             last_of_record_o
);

  logic             in_v_q;
  logic [7:0]       in_byte_q;
  logic             go;
  logic             res_valid;
  hrd_pkg::result_t res;
  hrd_pkg::result_t out_res;

  assign go         = in_v_q & (~out_valid_o | out_ready_i);
  assign in_ready_o = ~in_v_q | go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
  end

  hrd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .go_i        (go),
    .byte_i      (in_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  hrd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .res_o       (out_res)
  );

  assign kind_o           = out_res.kind;
  assign data_value_o     = out_res.data_value;
  assign byte_index_o     = out_res.byte_index;
  assign target_address_o = out_res.target_address;
  assign record_length_o  = out_res.record_length;
  assign record_type_o    = out_res.record_type;
  assign check_value_o    = out_res.check_value;
  assign segment_tag_o    = out_res.segment_tag;
  assign last_of_record_o = out_res.last_of_record;

endmodule

`default_nettype wire

// ===== hdl/hrd_checker.sv =====
// Port-level assertion checker for the hex record deframer, bound to the top level.
`default_nettype none
`include "hex_record_deframer_core_macros.svh"

module hrd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [2:0]  kind_o,
  input wire logic [7:0]  data_value_o,
  input wire logic [7:0]  byte_index_o,
  input wire logic [31:0] target_address_o,
  input wire logic        last_of_record_o
);

  `HRD_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) && $stable(target_address_o))
  `HRD_ASSERT(a_last_flag, out_valid_o |-> (last_of_record_o == (kind_o != hrd_pkg::KIND_DATA)))
  `HRD_ASSERT(a_cmd_clean, out_valid_o && kind_o != hrd_pkg::KIND_DATA |-> data_value_o == 8'd0 && byte_index_o == 8'd0)
  `HRD_ASSERT(a_addr_only_fw, out_valid_o && kind_o != hrd_pkg::KIND_FIRM_WRITE |-> target_address_o == 32'd0)
  `HRD_ASSERT(a_final_quiet, out_valid_o && out_ready_i && kind_o == hrd_pkg::KIND_APPLY_FINAL |=> !out_valid_o)

endmodule

bind hex_record_deframer_core hrd_checker u_hrd_checker (.*);

`default_nettype wire

// ===== tb/hex_record_deframer_core_tb.sv =====
// Self-checking testbench for hex_record_deframer_core: directed records, random streams, then closing records.
`timescale 1ns / 100ps

module hex_record_deframer_core_tb;

  localparam int WATCHDOG_LIMIT = 200;
  localparam int RANDOM_BYTES = 700;
  localparam int MAX_REPORTS = 10;
  localparam logic [7:0] SEG_CERT = 8'd2;
  localparam hrd_pkg::result_t NO_RESULT = '0;

  typedef struct packed {
    logic [7:0]       rx;
    logic             typed;
    hrd_pkg::result_t want;
  } stim_row_t;

  localparam int OPENING_COUNT = 28;
  localparam stim_row_t OPENING_ROWS [OPENING_COUNT] = '{
    '{8'h02, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{hrd_pkg::TYPE_BASE, 1'b0, NO_RESULT},
    '{8'hFF, 1'b1,
      '{hrd_pkg::KIND_DATA, 8'hFF, 8'd0, 32'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0}},
    '{8'hFF, 1'b1,
      '{hrd_pkg::KIND_DATA, 8'hFF, 8'd1, 32'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0}},
    '{8'h00, 1'b0, NO_RESULT},
    '{SEG_CERT, 1'b1,
      '{hrd_pkg::KIND_BASE_SET, 8'd0, 8'd0, 32'd0, 8'd2, hrd_pkg::TYPE_BASE, 8'h00,
        SEG_CERT, 1'b1}},
    '{8'h01, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{hrd_pkg::TYPE_DATA, 1'b0, NO_RESULT},
    '{8'h00, 1'b1,
      '{hrd_pkg::KIND_DATA, 8'h00, 8'd0, 32'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0}},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'hFF, 1'b1,
      '{hrd_pkg::KIND_FIRM_WRITE, 8'd0, 8'd0, 32'hFFFF_FFFF, 8'd1, hrd_pkg::TYPE_DATA,
        8'hFF, 8'hFF, 1'b1}},
    // short base record: missing second payload byte reads as zero
    '{8'h01, 1'b0, NO_RESULT},
    '{8'h12, 1'b0, NO_RESULT},
    '{8'h34, 1'b0, NO_RESULT},
    '{hrd_pkg::TYPE_BASE, 1'b0, NO_RESULT},
    '{8'hAB, 1'b1,
      '{hrd_pkg::KIND_DATA, 8'hAB, 8'd0, 32'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0}},
    '{8'h5A, 1'b0, NO_RESULT},
    '{hrd_pkg::SEG_FIRM, 1'b1,
      '{hrd_pkg::KIND_BASE_SET, 8'd0, 8'd0, 32'd0, 8'd1, hrd_pkg::TYPE_BASE, 8'h5A,
        hrd_pkg::SEG_FIRM, 1'b1}},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{hrd_pkg::TYPE_DATA, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{hrd_pkg::SEG_BOOT, 1'b1,
      '{hrd_pkg::KIND_BOOT_WRITE, 8'd0, 8'd0, 32'd0, 8'd0, hrd_pkg::TYPE_DATA, 8'h00,
        hrd_pkg::SEG_BOOT, 1'b1}}
  };

  // apply final, then bytes that must be dropped
  localparam int CLOSING_COUNT = 14;
  localparam stim_row_t CLOSING_ROWS [CLOSING_COUNT] = '{
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{hrd_pkg::TYPE_END, 1'b0, NO_RESULT},
    '{8'hC3, 1'b0, NO_RESULT},
    '{hrd_pkg::SEG_FIRM, 1'b1,
      '{hrd_pkg::KIND_APPLY_FINAL, 8'd0, 8'd0, 32'd0, 8'd0, hrd_pkg::TYPE_END, 8'hC3,
        hrd_pkg::SEG_FIRM, 1'b1}},
    '{8'h02, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{hrd_pkg::TYPE_DATA, 1'b0, NO_RESULT},
    '{8'h55, 1'b0, NO_RESULT},
    '{8'h66, 1'b0, NO_RESULT},
    '{8'h77, 1'b0, NO_RESULT},
    '{hrd_pkg::SEG_BOOT, 1'b0, NO_RESULT}
  };

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  kind_o;
  logic [7:0]  data_value_o;
  logic [7:0]  byte_index_o;
  logic [31:0] target_address_o;
  logic [7:0]  record_length_o;
  logic [7:0]  record_type_o;
  logic [7:0]  check_value_o;
  logic [7:0]  segment_tag_o;
  logic        last_of_record_o;

  hex_record_deframer_core uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .data_value_o     (data_value_o),
    .byte_index_o     (byte_index_o),
    .target_address_o (target_address_o),
    .record_length_o  (record_length_o),
    .record_type_o    (record_type_o),
    .check_value_o    (check_value_o),
    .segment_tag_o    (segment_tag_o),
    .last_of_record_o (last_of_record_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  hrd_pkg::phase_e parse_phase = hrd_pkg::PH_LEN;
  logic [7:0]  payload_count = '0;
  logic [7:0]  pend_len = '0;
  logic [15:0] pend_offset = '0;
  logic [7:0]  pend_type = '0;
  logic [7:0]  pend_check = '0;
  logic [15:0] staged_base = '0;
  logic [15:0] upper_base = '0;
  bit          parse_done = 1'b0;

  hrd_pkg::result_t pending_results[$];
  int      mismatches = 0;
  int      bytes_fed = 0;
  int      idle_cycles = 0;
  bit      feed_steady = 1'b0;
  bit      drain_steady = 1'b0;

  function automatic bit parse_byte(input logic [7:0] b, output hrd_pkg::result_t res);
    bit produced;
    res = '0;
    produced = 1'b0;
    if (!parse_done) begin
      case (parse_phase)
        hrd_pkg::PH_OFF_HI: begin
          pend_offset = {b, 8'h00};
          parse_phase = hrd_pkg::PH_OFF_LO;
        end
        hrd_pkg::PH_OFF_LO: begin
          pend_offset[7:0] = b;
          parse_phase = hrd_pkg::PH_TYPE;
        end
        hrd_pkg::PH_TYPE: begin
          pend_type = b;
          staged_base = '0;
          payload_count = '0;
          parse_phase = (pend_len == 8'd0) ? hrd_pkg::PH_CHECK : hrd_pkg::PH_DATA;
        end
        hrd_pkg::PH_DATA: begin
          res.kind = hrd_pkg::KIND_DATA;
          res.data_value = b;
          res.byte_index = payload_count;
          if (payload_count == 8'd0) staged_base = {b, 8'h00};
          else if (payload_count == 8'd1) staged_base[7:0] = b;
          payload_count = payload_count + 8'd1;
          if (payload_count == pend_len) parse_phase = hrd_pkg::PH_CHECK;
          produced = 1'b1;
        end
        hrd_pkg::PH_CHECK: begin
          pend_check = b;
          parse_phase = hrd_pkg::PH_SEG;
        end
        hrd_pkg::PH_SEG: begin
          parse_phase = hrd_pkg::PH_LEN;
          res.record_length = pend_len;
          res.record_type = pend_type;
          res.check_value = pend_check;
          res.segment_tag = b;
          res.last_of_record = 1'b1;
          if (pend_type == hrd_pkg::TYPE_DATA) begin
            if (b == hrd_pkg::SEG_BOOT) begin
              res.kind = hrd_pkg::KIND_BOOT_WRITE;
            end else begin
              res.kind = hrd_pkg::KIND_FIRM_WRITE;
              res.target_address = {upper_base, 16'h0000} + {16'h0000, pend_offset};
            end
          end else if (pend_type == hrd_pkg::TYPE_END) begin
            if (b == hrd_pkg::SEG_FIRM) begin
              res.kind = hrd_pkg::KIND_APPLY_FINAL;
              parse_done = 1'b1;
            end else begin
              res.kind = hrd_pkg::KIND_APPLY;
            end
          end else if (pend_type == hrd_pkg::TYPE_BASE) begin
            upper_base = staged_base;
            res.kind = hrd_pkg::KIND_BASE_SET;
          end else begin
            res.kind = hrd_pkg::KIND_IGNORED;
          end
          produced = 1'b1;
        end
        default: begin
          pend_len = b;
          parse_phase = hrd_pkg::PH_OFF_HI;
        end
      endcase
    end
    return produced;
  endfunction

  function automatic string describe(input hrd_pkg::result_t r);
    return $sformatf("k %0d v %02h i %0d a %08h l %0d t %02h c %02h s %02h e %0b",
                     r.kind, r.data_value, r.byte_index, r.target_address, r.record_length,
                     r.record_type, r.check_value, r.segment_tag, r.last_of_record);
  endfunction

  // random streams must not close an apply final record early
  function automatic logic [7:0] avoid_final(input logic [7:0] b);
    if (parse_phase == hrd_pkg::PH_SEG && pend_type == hrd_pkg::TYPE_END &&
        b == hrd_pkg::SEG_FIRM) return SEG_CERT;
    return b;
  endfunction

  task automatic feed_byte(input logic [7:0] b, input logic typed,
                           input hrd_pkg::result_t want);
    hrd_pkg::result_t predicted;
    if ($urandom_range(0, 39) == 0) feed_steady = !feed_steady;
    if (!feed_steady) begin
      repeat ($urandom_range(0, 3)) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    bytes_fed++;
    if (parse_byte(b, predicted)) pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic feed_random(input logic [7:0] b);
    feed_byte(avoid_final(b), 1'b0, NO_RESULT);
  endtask

  task automatic send_record();
    int         pick;
    logic [7:0] len;
    logic [7:0] kind_byte;
    logic [7:0] seg;
    pick = $urandom_range(0, 99);
    if (pick < 60) len = 8'($urandom_range(0, 4));
    else if (pick < 90) len = 8'($urandom_range(5, 16));
    else if (pick < 99) len = 8'($urandom_range(17, 64));
    else len = 8'($urandom_range(200, 255));
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      kind_byte = hrd_pkg::TYPE_DATA;
    end else if (pick < 60) begin
      kind_byte = hrd_pkg::TYPE_BASE;
      if ($urandom_range(0, 3) != 0) len = 8'd2;
    end else if (pick < 78) begin
      kind_byte = hrd_pkg::TYPE_END;
    end else begin
      kind_byte = 8'($urandom_range(0, 255));
    end
    pick = $urandom_range(0, 99);
    if (pick < 30) seg = hrd_pkg::SEG_BOOT;
    else if (pick < 55) seg = hrd_pkg::SEG_FIRM;
    else if (pick < 75) seg = SEG_CERT;
    else seg = 8'($urandom_range(0, 255));
    feed_random(len);
    feed_random(8'($urandom_range(0, 255)));
    feed_random(8'($urandom_range(0, 255)));
    feed_random(kind_byte);
    repeat (len) feed_random(8'($urandom_range(0, 255)));
    feed_random(8'($urandom_range(0, 255)));
    feed_random(seg);
  endtask

  task automatic realign();
    while (parse_phase != hrd_pkg::PH_LEN) feed_random(8'($urandom_range(0, 255)));
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < OPENING_COUNT; i++) begin
      feed_byte(OPENING_ROWS[i].rx, OPENING_ROWS[i].typed, OPENING_ROWS[i].want);
    end
    while (bytes_fed < OPENING_COUNT + RANDOM_BYTES) begin
      if ($urandom_range(0, 99) < 85) begin
        send_record();
      end else begin
        repeat ($urandom_range(1, 6)) feed_random(8'($urandom_range(0, 255)));
        realign();
      end
    end
    realign();
    for (int i = 0; i < CLOSING_COUNT; i++) begin
      feed_byte(CLOSING_ROWS[i].rx, CLOSING_ROWS[i].typed, CLOSING_ROWS[i].want);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin : result_check
    hrd_pkg::result_t seen;
    hrd_pkg::result_t want;
    forever begin
      if ($urandom_range(0, 39) == 0) drain_steady = !drain_steady;
      if (!drain_steady) begin
        repeat ($urandom_range(0, 3)) begin
          @(negedge clk_i);
          out_ready_i <= 1'b0;
        end
      end
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(rst_ni && out_valid_o === 1'b1));
      seen = '{kind_o, data_value_o, byte_index_o, target_address_o, record_length_o,
               record_type_o, check_value_o, segment_tag_o, last_of_record_o};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("unexpected item: %s", describe(seen));
      end else begin
        want = pending_results.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("item mismatch at %0t", $realtime);
            $display("  exp %s", describe(want));
            $display("  got %s", describe(seen));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o === 1'b1) || (out_valid_o === 1'b1 && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/hrd_pkg.sv
hdl/hrd_parser.sv
hdl/hrd_out_reg.sv
hdl/hex_record_deframer_core.sv
hdl/hrd_checker.sv
tb/hex_record_deframer_core_tb.sv
